/* design/bihl_pkg.sv */
package bihl_pkg;

  // Header geometry
  localparam int unsigned HEADER_WORDS     = 128;
  localparam int unsigned HDR_AW           = $clog2(HEADER_WORDS);
  localparam int unsigned MAX_PACKET_BYTES = 2047;

  // Field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned PB_W   = 11;
  localparam int unsigned BT_W   = 33;
  localparam int unsigned WIP_W  = 10;
  localparam int unsigned IDX_W  = 12;

  localparam logic [WIP_W-1:0]  WIP_MAX   = {WIP_W{1'b1}};
  localparam logic [BT_W-1:0]   BT_MAX    = {BT_W{1'b1}};
  localparam logic [PB_W-1:0]   PB_MAX    = PB_W'(MAX_PACKET_BYTES);
  localparam logic [BT_W-1:0]   HDR_BYTES = BT_W'(4 * HEADER_WORDS);
  localparam logic [IDX_W-1:0]  HDR_LIMIT = IDX_W'(HEADER_WORDS);

  localparam logic [WORD_W-1:0] SIG_RESET = 32'h4849_534E;

  // Header word positions
  localparam logic [HDR_AW-1:0] F_SIG   = HDR_AW'(HEADER_WORDS - 1);
  localparam logic [HDR_AW-1:0] F_LEN   = HDR_AW'(17);
  localparam logic [HDR_AW-1:0] F_BASE  = HDR_AW'(18);
  localparam logic [HDR_AW-1:0] F_ENTRY = HDR_AW'(19);

  // Opcodes
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Session phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;
  localparam logic [1:0] PH_FAILED  = 2'd3;

endpackage

/* design/bihl_if.sv */
interface bihl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [bihl_pkg::WORD_W-1:0]   word_data;
  logic [bihl_pkg::PB_W-1:0]     packet_bytes;
  logic                          last_word;

  modport source (output valid, opcode, word_data, packet_bytes, last_word, input ready);
  modport sink   (input valid, opcode, word_data, packet_bytes, last_word, output ready);
endinterface

interface bihl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          write_valid;
  logic [bihl_pkg::WORD_W-1:0]   write_address;
  logic [bihl_pkg::WORD_W-1:0]   write_word;
  logic                          stall_res;
  logic [1:0]                    session_status;
  logic [bihl_pkg::WORD_W-1:0]   loaded_base;
  logic [bihl_pkg::WORD_W-1:0]   launch_address;
  logic [bihl_pkg::WORD_W-1:0]   loaded_length;

  modport source (output valid, write_valid, write_address, write_word, stall_res,
                  session_status, loaded_base, launch_address, loaded_length,
                  input ready);
  modport sink   (input valid, write_valid, write_address, write_word, stall_res,
                  session_status, loaded_base, launch_address, loaded_length,
                  output ready);
endinterface

/* design/bihl_ram.sv */
module bihl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/boot_image_header_loader.sv */
// Boot image header loader. Bulk-OUT data comes in one 32-bit word per
// transaction, each tagged with its packet's byte count and a last-word flag;
// opcode 1 restarts the session. The first 512 bytes form the header and are
// kept in a 128-word header RAM at their running byte offset; an unaligned
// header packet is not stored, raises stall_res and restarts collection. When
// the header is complete, word 127 is checked against header_signature and,
// on a match, words 17/18/19 become image length, load base and launch
// address; a mismatch fails the session with a stall. Payload words are then
// issued as memory writes at base + running byte count until the length is
// reached. Every input transaction yields exactly one result transaction.
// Rate: one word per cycle while out_o.ready is high, with the output
// register decoupling the two sides. The word that completes the header
// holds off the input while the four header fields are fetched one by one
// through the RAM's single read port. Header RAM contents are undefined after
// reset: no clearing pass. header_signature may only be written while idle.

module boot_image_header_loader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bihl_pkg::WORD_W-1:0]   cfg_wdata_i,
  bihl_in_if.sink                       in_i,
  bihl_out_if.source                    out_o
);

  // Header check sequencer codes
  localparam logic [2:0] CK_IDLE     = 3'd0;
  localparam logic [2:0] CK_RD_SIG   = 3'd1;
  localparam logic [2:0] CK_RD_LEN   = 3'd2;
  localparam logic [2:0] CK_RD_BASE  = 3'd3;
  localparam logic [2:0] CK_RD_ENTRY = 3'd4;
  localparam logic [2:0] CK_DONE     = 3'd5;

  // Session state
  logic [bihl_pkg::WORD_W-1:0] sig_q;
  logic [1:0]                  phase_q, phase_d;
  logic [bihl_pkg::BT_W-1:0]   bt_q, bt_d;
  logic [bihl_pkg::WIP_W-1:0]  wip_q, wip_d;
  logic [bihl_pkg::WORD_W-1:0] len_q, len_d;
  logic [bihl_pkg::WORD_W-1:0] base_q, base_d;
  logic [bihl_pkg::WORD_W-1:0] entry_q, entry_d;

  // Header check
  logic [2:0]                  ck_q, ck_d;
  logic                        sig_ok_q;
  logic [bihl_pkg::WORD_W-1:0] hlen_q, hbase_q;

  // Output register
  logic                        ov_q, ov_d;
  logic                        o_wv_q, o_wv_d;
  logic [bihl_pkg::WORD_W-1:0] o_wa_q, o_wa_d;
  logic [bihl_pkg::WORD_W-1:0] o_wd_q, o_wd_d;
  logic                        o_stall_q, o_stall_d;
  logic [1:0]                  o_stat_q, o_stat_d;
  logic [bihl_pkg::WORD_W-1:0] o_base_q, o_base_d;
  logic [bihl_pkg::WORD_W-1:0] o_entry_q, o_entry_d;
  logic [bihl_pkg::WORD_W-1:0] o_len_q, o_len_d;

  // Per-word decode
  logic                          accept, out_free, load;
  logic [bihl_pkg::PB_W-1:0]     pb;
  logic                          in_range, aligned, live, is_hdr, is_pay, hdr_done;
  logic [bihl_pkg::IDX_W-1:0]    hdr_idx;
  logic [bihl_pkg::BT_W:0]       bt_raw;
  logic [bihl_pkg::BT_W-1:0]     bt_sum;
  logic [bihl_pkg::WORD_W-1:0]   pay_addr;

  // Header RAM
  logic                          ram_we;
  logic [bihl_pkg::HDR_AW-1:0]   ram_raddr;
  logic [bihl_pkg::WORD_W-1:0]   ram_rdata;

  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (ck_q == CK_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;

  // Oversized counts clamp to the packet limit
  assign pb = (in_i.packet_bytes > bihl_pkg::PB_MAX) ? bihl_pkg::PB_MAX : in_i.packet_bytes;

  assign in_range = {wip_q, 2'b00} < {1'b0, pb};
  assign aligned  = (pb[1:0] == 2'b00);
  assign live     = (in_i.opcode == bihl_pkg::OP_DATA) && (pb != '0) &&
                    ((phase_q == bihl_pkg::PH_HEADER) || (phase_q == bihl_pkg::PH_PAYLOAD));
  assign is_hdr   = live && (phase_q == bihl_pkg::PH_HEADER);
  assign is_pay   = live && (phase_q == bihl_pkg::PH_PAYLOAD);

  // In the header phase the byte count stays below the header size
  assign hdr_idx = bt_q[bihl_pkg::IDX_W+1:2] + bihl_pkg::IDX_W'(wip_q);

  assign bt_raw = {1'b0, bt_q} + (bihl_pkg::BT_W + 1)'(pb);
  assign bt_sum = bt_raw[bihl_pkg::BT_W] ? bihl_pkg::BT_MAX : bt_raw[bihl_pkg::BT_W-1:0];

  assign hdr_done = is_hdr && in_i.last_word && aligned && (bt_sum >= bihl_pkg::HDR_BYTES);

  assign pay_addr = base_q + bt_q[bihl_pkg::WORD_W-1:0] +
                    bihl_pkg::WORD_W'({wip_q, 2'b00});

  assign ram_we = accept && is_hdr && in_range && aligned && (hdr_idx < bihl_pkg::HDR_LIMIT);

  // Read address follows the check sequencer; parked on the entry word so
  // the data stays put in the final step.
  always_comb begin
    case (ck_q)
      CK_RD_SIG:  ram_raddr = bihl_pkg::F_SIG;
      CK_RD_LEN:  ram_raddr = bihl_pkg::F_LEN;
      CK_RD_BASE: ram_raddr = bihl_pkg::F_BASE;
      default:    ram_raddr = bihl_pkg::F_ENTRY;
    endcase
  end

  bihl_ram #(
    .Width (bihl_pkg::WORD_W),
    .Depth (bihl_pkg::HEADER_WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (hdr_idx[bihl_pkg::HDR_AW-1:0]),
    .wdata_i (in_i.word_data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next-state and result
  always_comb begin
    phase_d   = phase_q;
    bt_d      = bt_q;
    wip_d     = wip_q;
    len_d     = len_q;
    base_d    = base_q;
    entry_d   = entry_q;
    ck_d      = ck_q;
    load      = 1'b0;
    o_wv_d    = 1'b0;
    o_wa_d    = '0;
    o_wd_d    = '0;
    o_stall_d = 1'b0;

    if (accept) begin
      if (in_i.opcode == bihl_pkg::OP_RESTART) begin
        phase_d = bihl_pkg::PH_HEADER;
        bt_d    = '0;
        wip_d   = '0;
      end else if (live) begin
        if (is_hdr && in_i.last_word) begin
          if (!aligned) begin
            o_stall_d = 1'b1;
            bt_d      = '0;
          end else if (hdr_done) begin
            bt_d = '0;
            ck_d = CK_RD_SIG;
          end else begin
            bt_d = bt_sum;
          end
        end
        if (is_pay) begin
          if (in_range) begin
            o_wv_d = 1'b1;
            o_wa_d = pay_addr;
            o_wd_d = in_i.word_data;
          end
          if (in_i.last_word) begin
            bt_d = bt_sum;
            if (bt_sum >= {1'b0, len_q}) begin
              phase_d = bihl_pkg::PH_DONE;
            end
          end
        end
        if (in_i.last_word) begin
          wip_d = '0;
        end else if (wip_q != bihl_pkg::WIP_MAX) begin
          wip_d = wip_q + 1'b1;
        end
      end
      load = !hdr_done;
    end

    case (ck_q)
      CK_IDLE:     ck_d = ck_d;
      CK_RD_SIG:   ck_d = CK_RD_LEN;
      CK_RD_LEN:   ck_d = CK_RD_BASE;
      CK_RD_BASE:  ck_d = CK_RD_ENTRY;
      CK_RD_ENTRY: ck_d = CK_DONE;
      CK_DONE: begin
        if (out_free) begin
          ck_d = CK_IDLE;
          load = 1'b1;
          if (sig_ok_q) begin
            phase_d = bihl_pkg::PH_PAYLOAD;
            len_d   = hlen_q;
            base_d  = hbase_q;
            entry_d = ram_rdata;
          end else begin
            phase_d   = bihl_pkg::PH_FAILED;
            o_stall_d = 1'b1;
          end
        end
      end
      default:     ck_d = CK_IDLE;
    endcase

    o_stat_d  = phase_d;
    o_base_d  = base_d;
    o_entry_d = entry_d;
    o_len_d   = len_d;

    if (load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q   <= bihl_pkg::SIG_RESET;
      phase_q <= bihl_pkg::PH_HEADER;
      bt_q    <= '0;
      wip_q   <= '0;
      len_q   <= '0;
      base_q  <= '0;
      entry_q <= '0;
      ck_q    <= CK_IDLE;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sig_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      bt_q    <= bt_d;
      wip_q   <= wip_d;
      len_q   <= len_d;
      base_q  <= base_d;
      entry_q <= entry_d;
      ck_q    <= ck_d;
      ov_q    <= ov_d;
    end
  end

  // Fetched header fields, captured from the registered RAM read data
  always_ff @(posedge clk_i) begin
    if (ck_q == CK_RD_LEN) begin
      sig_ok_q <= (ram_rdata == sig_q);
    end
    if (ck_q == CK_RD_BASE) begin
      hlen_q <= ram_rdata;
    end
    if (ck_q == CK_RD_ENTRY) begin
      hbase_q <= ram_rdata;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      o_wv_q    <= o_wv_d;
      o_wa_q    <= o_wa_d;
      o_wd_q    <= o_wd_d;
      o_stall_q <= o_stall_d;
      o_stat_q  <= o_stat_d;
      o_base_q  <= o_base_d;
      o_entry_q <= o_entry_d;
      o_len_q   <= o_len_d;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.write_valid    = o_wv_q;
  assign out_o.write_address  = o_wa_q;
  assign out_o.write_word     = o_wd_q;
  assign out_o.stall_res      = o_stall_q;
  assign out_o.session_status = o_stat_q;
  assign out_o.loaded_base    = o_base_q;
  assign out_o.launch_address = o_entry_q;
  assign out_o.loaded_length  = o_len_q;

endmodule
